@@ rtl/cfhc_pkg.sv @@
package cfhc_pkg;

   localparam int DATA_WIDTH        = 32;
   localparam int SIDE_WIDTH        = 16;
   localparam int BYTE_WIDTH        = 8;
   localparam int WORD_WIDTH        = 16;
   localparam int SHIFT_WIDTH       = 5;
   localparam int SLOT_BITS_WIDTH   = 5;
   localparam int SLOT_WIDTH        = 16;
   localparam int CSR_INDEX_WIDTH   = 3;
   localparam int TABLE_DEPTH       = 256;
   localparam int MAX_SLOT_BITS_DEF = 16;
   localparam int COUNT_WIDTH_DEF   = 24;
   localparam int MUL_SHIFT         = 5;

   localparam logic [BYTE_WIDTH-1:0] FOLD_MASK = 8'h20;

   localparam logic [DATA_WIDTH-1:0]      SEED_RESET      = '0;
   localparam logic [DATA_WIDTH-1:0]      MODULUS_RESET   = 32'd1;
   localparam logic [SLOT_BITS_WIDTH-1:0] SLOT_BITS_RESET = 5'd8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED         = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_FIRST  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHIFT_SECOND = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIX_OFFSET   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOT_BITS    = 3'd5;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_START,
      OP_CHAR,
      OP_END
   } opcode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHAR,
      ST_DIV,
      ST_MIX,
      ST_LOOK,
      ST_MARK
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DATA_WIDTH-1:0] remainder;
   } div_rsp_type;

endpackage

@@ rtl/cfhc_if.sv @@
interface cfhc_req_if import cfhc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   opcode_type            opcode;
   logic [BYTE_WIDTH-1:0] table_index;
   logic [WORD_WIDTH-1:0] table_word;
   logic [BYTE_WIDTH-1:0] char_byte;

   modport source (output valid, opcode, table_index, table_word, char_byte, input ready);
   modport sink (input valid, opcode, table_index, table_word, char_byte, output ready);
endinterface

interface cfhc_rsp_if import cfhc_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [DATA_WIDTH-1:0]  hash_value;
   logic [SLOT_WIDTH-1:0]  slot;
   logic                   collided;
   logic [COUNT_WIDTH-1:0] strings_seen;
   logic [COUNT_WIDTH-1:0] collision_total;
   logic [COUNT_WIDTH-1:0] score;

   modport source (output valid, hash_value, slot, collided, strings_seen, collision_total,
                   score, input ready);
   modport sink (input valid, hash_value, slot, collided, strings_seen, collision_total,
                 score, output ready);
endinterface

interface cfhc_csr_if import cfhc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [DATA_WIDTH-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/cfhc_ram.sv @@
module cfhc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cfhc_divider.sv @@
module cfhc_divider import cfhc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEP_WIDTH = $clog2(DATA_WIDTH);
   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(DATA_WIDTH - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DATA_WIDTH-1:0] dsr_ff, dsr_in;
   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[DATA_WIDTH-1]};
      diff    = trial - {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = div_req.dividend;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = diff[DATA_WIDTH] ? trial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
         dvd_in  = {dvd_ff[DATA_WIDTH-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

@@ rtl/casefold_hash_collision_scorer.sv @@
// A load transfer leaves the block in ST_IDLE, a character transfer passes through ST_CHAR,
// and a start transfer through ST_CLEAR while the hit map is swept clear one entry per cycle.
// An end-of-string transfer passes through ST_DIV (skipped with modulus zero), ST_MIX,
// ST_LOOK and ST_MARK; the radix-2 remainder unit retires one dividend bit per cycle.
// Reset is synchronous: control, counter and CSR registers take their reset values and the
// hit map is swept clear, during which requests stall and CSR writes are still taken.
module casefold_hash_collision_scorer import cfhc_pkg::*; #(
   parameter int MAX_SLOT_BITS = MAX_SLOT_BITS_DEF,
   parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   cfhc_csr_if.sink    csr_chan,
   cfhc_req_if.sink    req_chan,
   cfhc_rsp_if.source  rsp_chan
);

   localparam int MAP_DEPTH   = 1 << MAX_SLOT_BITS;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam logic [SLOT_BITS_WIDTH-1:0] MAX_BITS = SLOT_BITS_WIDTH'(MAX_SLOT_BITS);

   state_type state_ff, state_in;

   logic [DATA_WIDTH-1:0]      seed_ff;
   logic [SHIFT_WIDTH-1:0]     shift_first_ff;
   logic [SHIFT_WIDTH-1:0]     shift_second_ff;
   logic [DATA_WIDTH-1:0]      mix_offset_ff;
   logic [DATA_WIDTH-1:0]      modulus_ff;
   logic [SLOT_BITS_WIDTH-1:0] slot_bits_ff;

   logic [DATA_WIDTH-1:0]    main_ff, main_in;
   logic [SIDE_WIDTH-1:0]    side_ff, side_in;
   logic [DATA_WIDTH-1:0]    h_ff, h_in;
   logic [DATA_WIDTH-1:0]    hash_ff, hash_in;
   logic [MAX_SLOT_BITS-1:0] slot_ff, slot_in;
   logic [MAX_SLOT_BITS-1:0] clr_ff, clr_in;
   logic [COUNT_WIDTH-1:0]   str_cnt_ff, str_cnt_in;
   logic [COUNT_WIDTH-1:0]   col_cnt_ff, col_cnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]  rsp_hash_ff, rsp_hash_in;
   logic [SLOT_WIDTH-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [COUNT_WIDTH-1:0] rsp_str_ff, rsp_str_in;
   logic [COUNT_WIDTH-1:0] rsp_col_ff, rsp_col_in;
   logic [COUNT_WIDTH-1:0] rsp_score_ff, rsp_score_in;

   logic                   req_xfer;
   logic [BYTE_WIDTH-1:0]  folded;
   logic                   tbl_wr_en;
   logic [WORD_WIDTH-1:0]  tbl_rd_data;
   logic                   map_wr_en;
   logic [MAX_SLOT_BITS-1:0] map_wr_addr;
   logic                   map_wr_data;
   logic                   map_rd_data;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign folded         = req_chan.char_byte | FOLD_MASK;
   assign tbl_wr_en      = req_xfer && (req_chan.opcode == OP_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff         <= SEED_RESET;
         shift_first_ff  <= '0;
         shift_second_ff <= '0;
         mix_offset_ff   <= '0;
         modulus_ff      <= MODULUS_RESET;
         slot_bits_ff    <= SLOT_BITS_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_SEED:         seed_ff         <= csr_chan.data;
            CSR_SHIFT_FIRST:  shift_first_ff  <= csr_chan.data[SHIFT_WIDTH-1:0];
            CSR_SHIFT_SECOND: shift_second_ff <= csr_chan.data[SHIFT_WIDTH-1:0];
            CSR_MIX_OFFSET:   mix_offset_ff   <= csr_chan.data;
            CSR_MODULUS:      modulus_ff      <= csr_chan.data;
            CSR_SLOT_BITS:    slot_bits_ff    <= csr_chan.data[SLOT_BITS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   cfhc_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (req_chan.table_index[TABLE_AW-1:0]),
      .wr_data (req_chan.table_word),
      .rd_addr (folded[TABLE_AW-1:0]),
      .rd_data (tbl_rd_data)
   );

   cfhc_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_hit_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (slot_ff),
      .rd_data (map_rd_data)
   );

   cfhc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      logic [SLOT_BITS_WIDTH-1:0] eff_bits;
      logic [MAX_SLOT_BITS-1:0]   slot_mask;
      logic [DATA_WIDTH-1:0]      mixed;
      logic [DATA_WIDTH-1:0]      combined;
      logic [COUNT_WIDTH-1:0]     str_next;
      logic [COUNT_WIDTH-1:0]     col_next;

      if (slot_bits_ff == '0) begin
         eff_bits = SLOT_BITS_WIDTH'(1);
      end else if (slot_bits_ff > MAX_BITS) begin
         eff_bits = MAX_BITS;
      end else begin
         eff_bits = slot_bits_ff;
      end
      for (int i = 0; i < MAX_SLOT_BITS; i++) begin
         slot_mask[i] = (SLOT_BITS_WIDTH'(i) < eff_bits);
      end
      mixed    = (h_ff >> shift_first_ff) ^ ((h_ff >> shift_second_ff) + mix_offset_ff);
      combined = main_ff ^ DATA_WIDTH'(side_ff);
      str_next = (str_cnt_ff == '1) ? str_cnt_ff : str_cnt_ff + 1'b1;
      col_next = (map_rd_data && (col_cnt_ff != '1)) ? col_cnt_ff + 1'b1 : col_cnt_ff;

      state_in     = state_ff;
      main_in      = main_ff;
      side_in      = side_ff;
      h_in         = h_ff;
      hash_in      = hash_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      str_cnt_in   = str_cnt_ff;
      col_cnt_in   = col_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hash_in  = rsp_hash_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_str_in   = rsp_str_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_score_in = rsp_score_ff;
      map_wr_en    = 1'b0;
      map_wr_addr  = clr_ff;
      map_wr_data  = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = combined;
      div_req.divisor  = modulus_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            map_wr_en = 1'b1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (req_chan.opcode)
                  OP_LOAD: ;
                  OP_START: begin
                     main_in    = seed_ff;
                     side_in    = '0;
                     str_cnt_in = '0;
                     col_cnt_in = '0;
                     clr_in     = '0;
                     state_in   = ST_CLEAR;
                  end
                  OP_CHAR: begin
                     main_in  = ((main_ff << MUL_SHIFT) + main_ff) ^ DATA_WIDTH'(folded);
                     state_in = ST_CHAR;
                  end
                  OP_END: begin
                     main_in = seed_ff;
                     side_in = '0;
                     h_in    = combined;
                     if (modulus_ff != '0) begin
                        div_req.start = 1'b1;
                        state_in      = ST_DIV;
                     end else begin
                        state_in = ST_MIX;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CHAR: begin
            side_in  = side_ff ^ tbl_rd_data;
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               h_in     = div_rsp.remainder;
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            hash_in  = mixed;
            slot_in  = mixed[MAX_SLOT_BITS-1:0] & slot_mask;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_MARK;
         end
         ST_MARK: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               map_wr_en    = 1'b1;
               map_wr_addr  = slot_ff;
               map_wr_data  = 1'b1;
               str_cnt_in   = str_next;
               col_cnt_in   = col_next;
               rsp_valid_in = 1'b1;
               rsp_hash_in  = hash_ff;
               rsp_slot_in  = SLOT_WIDTH'(slot_ff);
               rsp_hit_in   = map_rd_data;
               rsp_str_in   = str_next;
               rsp_col_in   = col_next;
               rsp_score_in = (col_next > str_next) ? '0 : str_next - col_next;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         main_ff      <= '0;
         side_ff      <= '0;
         str_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         main_ff      <= main_in;
         side_ff      <= side_in;
         str_cnt_ff   <= str_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      h_ff         <= h_in;
      hash_ff      <= hash_in;
      slot_ff      <= slot_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_str_ff   <= rsp_str_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_score_ff <= rsp_score_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.hash_value      = rsp_hash_ff;
   assign rsp_chan.slot            = rsp_slot_ff;
   assign rsp_chan.collided        = rsp_hit_ff;
   assign rsp_chan.strings_seen    = rsp_str_ff;
   assign rsp_chan.collision_total = rsp_col_ff;
   assign rsp_chan.score           = rsp_score_ff;

endmodule

@@ verif/casefold_hash_collision_scorer_tb.sv @@
module casefold_hash_collision_scorer_tb import cfhc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_ITEMS = 250;
   localparam int RANDOM_PHASES = 8;
   localparam int MAP_DEPTH = 1 << MAX_SLOT_BITS_DEF;
   localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;

   typedef struct {
      opcode_type            op;
      logic [BYTE_WIDTH-1:0] index;
      logic [WORD_WIDTH-1:0] word;
      logic [BYTE_WIDTH-1:0] chr;
   } hash_item_t;

   typedef struct {
      logic [DATA_WIDTH-1:0]      hash_value;
      logic [SLOT_WIDTH-1:0]      slot;
      logic                       collided;
      logic [COUNT_WIDTH_DEF-1:0] strings_seen;
      logic [COUNT_WIDTH_DEF-1:0] collision_total;
      logic [COUNT_WIDTH_DEF-1:0] score;
   } score_rec_t;

   logic clock;
   logic reset;

   cfhc_csr_if csr ();
   cfhc_req_if req ();
   cfhc_rsp_if #(.COUNT_WIDTH(COUNT_WIDTH_DEF)) rsp ();

   casefold_hash_collision_scorer #(
      .MAX_SLOT_BITS(MAX_SLOT_BITS_DEF),
      .COUNT_WIDTH(COUNT_WIDTH_DEF)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_chan(csr),
      .req_chan(req),
      .rsp_chan(rsp)
   );

   hash_item_t pending_items [$];
   score_rec_t scores_due [$];
   hash_item_t live_item;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatches = 0;
   int transfers_in = 0;
   int results_checked = 0;
   int collisions_seen = 0;
   int settings_used = 0;
   int unsigned cycle_count = 0;

   logic [DATA_WIDTH-1:0]      cfg_seed;
   logic [SHIFT_WIDTH-1:0]     cfg_shift_first;
   logic [SHIFT_WIDTH-1:0]     cfg_shift_second;
   logic [DATA_WIDTH-1:0]      cfg_mix_offset;
   logic [DATA_WIDTH-1:0]      cfg_modulus;
   logic [SLOT_BITS_WIDTH-1:0] cfg_slot_bits;

   logic [DATA_WIDTH-1:0] acc_main;
   logic [SIDE_WIDTH-1:0] acc_side;
   logic [WORD_WIDTH-1:0] lut_words [0:TABLE_DEPTH-1];
   bit                    map_hits [0:MAP_DEPTH-1];
   int unsigned           strings_done;
   int unsigned           collisions_done;
   bit                    table_loaded [0:TABLE_DEPTH-1];

   initial begin
      cfg_seed = SEED_RESET;
      cfg_shift_first = '0;
      cfg_shift_second = '0;
      cfg_mix_offset = '0;
      cfg_modulus = MODULUS_RESET;
      cfg_slot_bits = SLOT_BITS_RESET;
      acc_main = '0;
      acc_side = '0;
      strings_done = 0;
      collisions_done = 0;
      foreach (lut_words[i]) lut_words[i] = '0;
      foreach (map_hits[i]) map_hits[i] = 1'b0;
      foreach (table_loaded[i]) table_loaded[i] = 1'b0;
   end

   function automatic void step_hash_scorer(input hash_item_t it);
      logic [BYTE_WIDTH-1:0] folded;
      logic [DATA_WIDTH-1:0] h;
      logic [DATA_WIDTH-1:0] hash;
      logic [DATA_WIDTH-1:0] mask;
      logic [DATA_WIDTH-1:0] slot;
      int bits;
      bit hit;
      score_rec_t rec;
      case (it.op)
         OP_LOAD: begin
            lut_words[it.index] = it.word;
         end
         OP_START: begin
            foreach (map_hits[i]) map_hits[i] = 1'b0;
            strings_done = 0;
            collisions_done = 0;
            acc_main = cfg_seed;
            acc_side = '0;
         end
         OP_CHAR: begin
            folded = it.chr | FOLD_MASK;
            acc_side ^= lut_words[folded];
            acc_main = ((acc_main << MUL_SHIFT) + acc_main) ^ {24'd0, folded};
         end
         OP_END: begin
            h = acc_main ^ {16'd0, acc_side};
            if (cfg_modulus != '0) h = h % cfg_modulus;
            hash = (h >> cfg_shift_first) ^ ((h >> cfg_shift_second) + cfg_mix_offset);
            bits = int'(cfg_slot_bits);
            if (bits < 1) bits = 1;
            if (bits > MAX_SLOT_BITS_DEF) bits = MAX_SLOT_BITS_DEF;
            mask = (32'd1 << bits) - 32'd1;
            slot = hash & mask;
            hit = map_hits[slot[SLOT_WIDTH-1:0]];
            map_hits[slot[SLOT_WIDTH-1:0]] = 1'b1;
            if (strings_done < COUNT_MAX) strings_done++;
            if (hit && collisions_done < COUNT_MAX) collisions_done++;
            rec.hash_value = hash;
            rec.slot = slot[SLOT_WIDTH-1:0];
            rec.collided = hit;
            rec.strings_seen = strings_done[COUNT_WIDTH_DEF-1:0];
            rec.collision_total = collisions_done[COUNT_WIDTH_DEF-1:0];
            rec.score = (collisions_done > strings_done) ? '0
                        : COUNT_WIDTH_DEF'(strings_done - collisions_done);
            scores_due.push_back(rec);
            acc_main = cfg_seed;
            acc_side = '0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at result %0d, %s: got %h, expected %h",
               results_checked, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   initial begin
      clock = 1'b0;
      csr.valid = 1'b0;
      csr.index = CSR_SEED;
      csr.data = '0;
      req.valid = 1'b0;
      req.opcode = OP_LOAD;
      req.table_index = '0;
      req.table_word = '0;
      req.char_byte = '0;
      rsp.ready = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, scores_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // A new item is presented only once the previous transfer has completed.
   always @(posedge clock) begin : req_driver
      hash_item_t nxt;
      if (reset) begin
         req.valid <= 1'b0;
      end else begin
         if (req.valid && req.ready) begin
            step_hash_scorer(live_item);
            transfers_in++;
         end
         if (!req.valid || req.ready) begin
            if (pending_items.size() != 0 &&
                !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)) begin
               nxt = pending_items.pop_front();
               live_item <= nxt;
               req.valid <= 1'b1;
               req.opcode <= nxt.op;
               req.table_index <= nxt.index;
               req.table_word <= nxt.word;
               req.char_byte <= nxt.chr;
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      score_rec_t want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (scores_due.size() == 0) begin
               report_mismatch("result with nothing expected", rsp.hash_value, '0);
            end else begin
               want = scores_due.pop_front();
               check_field("hash_value", rsp.hash_value, want.hash_value);
               check_field("slot", 32'(rsp.slot), 32'(want.slot));
               check_field("collided", 32'(rsp.collided), 32'(want.collided));
               check_field("strings_seen", 32'(rsp.strings_seen), 32'(want.strings_seen));
               check_field("collision_total", 32'(rsp.collision_total),
                           32'(want.collision_total));
               check_field("score", 32'(rsp.score), 32'(want.score));
            end
            if (rsp.collided === 1'b1) collisions_seen++;
            results_checked++;
         end
         rsp.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic hash_item_t make_item(input opcode_type op,
                                            input logic [BYTE_WIDTH-1:0] idx,
                                            input logic [WORD_WIDTH-1:0] word,
                                            input logic [BYTE_WIDTH-1:0] chr);
      hash_item_t it;
      it.op = op;
      it.index = idx;
      it.word = word;
      it.chr = chr;
      return it;
   endfunction

   task automatic queue_item(input hash_item_t it);
      if (it.op == OP_LOAD) table_loaded[it.index] = 1'b1;
      pending_items.push_back(it);
   endtask

   // Characters come from loaded lookup entries, else 8'h61, with the FOLD_MASK bit cleared at random.
   function automatic logic [BYTE_WIDTH-1:0] pick_char();
      logic [BYTE_WIDTH-1:0] r;
      r = 8'h61;
      for (int tries = 0; tries < 32; tries++) begin
         r = BYTE_WIDTH'($urandom_range(255)) | FOLD_MASK;
         if (table_loaded[r]) break;
         r = 8'h61;
      end
      if ($urandom_range(1) == 0 && (r & ~FOLD_MASK) != '0) r = r & ~FOLD_MASK;
      return r;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      case (idx)
         CSR_SEED:         cfg_seed = value;
         CSR_SHIFT_FIRST:  cfg_shift_first = value[SHIFT_WIDTH-1:0];
         CSR_SHIFT_SECOND: cfg_shift_second = value[SHIFT_WIDTH-1:0];
         CSR_MIX_OFFSET:   cfg_mix_offset = value;
         CSR_MODULUS:      cfg_modulus = value;
         CSR_SLOT_BITS:    cfg_slot_bits = value[SLOT_BITS_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all_regs(input logic [31:0] seed, input logic [31:0] sf,
                                 input logic [31:0] ss, input logic [31:0] off,
                                 input logic [31:0] modv, input logic [31:0] bits);
      write_reg(CSR_SEED, seed);
      write_reg(CSR_SHIFT_FIRST, sf);
      write_reg(CSR_SHIFT_SECOND, ss);
      write_reg(CSR_MIX_OFFSET, off);
      write_reg(CSR_MODULUS, modv);
      write_reg(CSR_SLOT_BITS, bits);
      settings_used++;
   endtask

   task automatic wait_drained(input int settle);
      do @(negedge clock);
      while (pending_items.size() != 0 || req.valid || scores_due.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   task automatic configure_phase(input int p);
      logic [31:0] seed;
      logic [31:0] sf;
      logic [31:0] ss;
      logic [31:0] off;
      logic [31:0] modv;
      logic [31:0] bits;
      seed = $urandom;
      sf = $urandom_range(31);
      ss = $urandom_range(31);
      off = $urandom;
      modv = $urandom_range(1000, 2);
      bits = $urandom_range(16, 1);
      case (p)
         0: begin
            seed = '0;
            sf = 0;
            ss = 0;
            off = '0;
            modv = '0;
            bits = 1;
         end
         1: begin
            seed = '1;
            sf = 31;
            ss = 31;
            off = '1;
            modv = '1;
            bits = 16;
         end
         2: bits = 0;
         3: begin
            modv = 1;
            bits = 31;
         end
         4: begin
            modv = $urandom;
            bits = 17;
         end
         5: begin
            modv = '0;
            bits = 4;
         end
         6: begin
            modv = $urandom_range(100000, 2);
            bits = 12;
            sf = 0;
            ss = 16;
         end
         default: begin
            modv = $urandom;
            bits = $urandom_range(31);
         end
      endcase
      write_all_regs(seed, sf, ss, off, modv, bits);
   endtask

   // Strings are well formed for the most part; loads and one start transfer land
   // at random points, often in the middle of a string.
   task automatic run_random_phase(input int phase_items, input bit pause_midway);
      int len;
      int issued;
      int start_at;
      bit started;
      bit paused;
      issued = 0;
      started = 1'b0;
      paused = !pause_midway;
      start_at = $urandom_range(phase_items - 50, 0);
      @(negedge clock);
      while (issued < phase_items) begin
         len = ($urandom_range(7) == 0) ? 0 : $urandom_range(12, 1);
         for (int k = 0; k <= len; k++) begin
            if (!started && issued >= start_at) begin
               queue_item(make_item(OP_START, BYTE_WIDTH'($urandom), WORD_WIDTH'($urandom),
                                    BYTE_WIDTH'($urandom)));
               started = 1'b1;
               issued++;
            end
            if (!paused && issued >= phase_items / 2) begin
               paused = 1'b1;
               wait_drained(0);
            end
            if (k == len) begin
               queue_item(make_item(OP_END, BYTE_WIDTH'($urandom), WORD_WIDTH'($urandom),
                                    BYTE_WIDTH'($urandom)));
            end else begin
               if ($urandom_range(9) == 0) begin
                  queue_item(make_item(OP_LOAD, BYTE_WIDTH'($urandom_range(255)),
                                       WORD_WIDTH'($urandom), BYTE_WIDTH'($urandom)));
                  issued++;
               end
               queue_item(make_item(OP_CHAR, BYTE_WIDTH'($urandom), WORD_WIDTH'($urandom),
                                    pick_char()));
            end
            issued++;
         end
      end
   endtask

   initial begin : stimulus
      do @(negedge clock); while (reset);

      // Reset settings, strings finished with no start transfer first.
      queue_item(make_item(OP_LOAD, 8'h00, 16'hFFFF, 8'h00));
      queue_item(make_item(OP_LOAD, 8'hFF, 16'h0001, 8'hFF));
      queue_item(make_item(OP_LOAD, 8'h61, 16'hA5C3, 8'h00));
      queue_item(make_item(OP_LOAD, 8'h20, 16'h5A3C, 8'h00));
      queue_item(make_item(OP_END, 8'h00, 16'h0000, 8'h00));
      queue_item(make_item(OP_CHAR, 8'h00, 16'h0000, 8'h41));
      queue_item(make_item(OP_CHAR, 8'hFF, 16'hFFFF, 8'hFF));
      queue_item(make_item(OP_END, 8'hFF, 16'hFFFF, 8'hFF));
      wait_drained(SETTLE_CYCLES);

      write_all_regs($urandom, 0, 0, 0, 0, 16);
      @(negedge clock);
      queue_item(make_item(OP_START, 8'h00, 16'h0000, 8'h00));
      queue_item(make_item(OP_CHAR, 8'h00, 16'h0000, 8'h61));
      queue_item(make_item(OP_CHAR, 8'h00, 16'h0000, 8'h00));
      queue_item(make_item(OP_CHAR, 8'h00, 16'h0000, 8'hDF));
      queue_item(make_item(OP_END, 8'h00, 16'h0000, 8'h00));
      queue_item(make_item(OP_END, 8'h00, 16'h0000, 8'h00));
      queue_item(make_item(OP_CHAR, 8'h00, 16'h0000, 8'h20));
      queue_item(make_item(OP_END, 8'h00, 16'h0000, 8'h00));
      wait_drained(SETTLE_CYCLES);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 56;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 56;
            end
            default: begin
               send_idle_pct = 20;
               recv_stall_pct = 20;
            end
         endcase
         configure_phase(p);
         run_random_phase(PHASE_ITEMS, p == 2);
         wait_drained(SETTLE_CYCLES);
      end

      $display("Sent %0d transfers under %0d register settings and four idling patterns;",
               transfers_in, settings_used);
      $display("checked %0d hash results, %0d of them slot collisions, %0d mismatches.",
               results_checked, collisions_seen, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/cfhc_pkg.sv
rtl/cfhc_if.sv
rtl/cfhc_ram.sv
rtl/cfhc_divider.sv
rtl/casefold_hash_collision_scorer.sv
verif/casefold_hash_collision_scorer_tb.sv
